[rtl/kot_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kot_pkg: shared types and constants of the keyed override table
// Request and result structs, table entry layouts, codes and scan states.
// ----------------------------------------------------------------------------
package kot_pkg;

	localparam int TABLE_DEPTH_DEF = 24;

	localparam logic [7:0] ITEM_LIMIT = 8'd76;
	localparam logic [1:0] HALF_ANY   = 2'd2;

	// request codes
	localparam logic [1:0] REQ_SET    = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	// result status codes
	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_CLEARED = 3'd3;
	localparam logic [2:0] ST_HIT     = 3'd4;
	localparam logic [2:0] ST_MISS    = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_LOOKUPS_ENABLED = 2'd0;
	localparam logic [1:0] CFG_VIRTUAL_ID_LOW  = 2'd1;
	localparam logic [1:0] CFG_VIRTUAL_ID_HIGH = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [15:0]        area;
		logic               indoors;
		logic [7:0]         sprite;
		logic [1:0]         half;
		logic [7:0]         item;
		logic signed [15:0] message_id;
		logic signed [15:0] report_id;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         found_item;
		logic signed [15:0] found_message_id;
		logic signed [15:0] found_report_id;
	} res_t;

	typedef struct packed {
		logic [15:0] area;
		logic        indoors;
		logic [7:0]  sprite;
		logic [1:0]  half;
	} key_t;

	typedef struct packed {
		logic [7:0]         item;
		logic signed [15:0] message_id;
		logic signed [15:0] report_id;
	} payload_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESULT
	} state_t;

	// result with empty payload fields
	function automatic res_t empty_res(input logic [2:0] status);
		res_t r;
		r.status           = status;
		r.found_item       = 8'd0;
		r.found_message_id = -16'sd1;
		r.found_report_id  = -16'sd1;
		return r;
	endfunction

endpackage

[rtl/kot_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kot_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module kot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 24,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/keyed_override_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_override_table_unit: keyed substitution table with scan lookup
// Holds up to TABLE_DEPTH keyed entries in two synchronous RAMs and serves
// set, clear and lookup requests; sets and enabled lookups scan the table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with an in_req struct; each request
//   produces exactly one result on out_valid/out_stall as an out_res struct.
//   Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
//   while the unit is idle.
//   Set and enabled lookup requests scan the filled entries in order: one
//   key/payload RAM read is issued per cycle, and each read is compared in
//   the cycle after it is issued. The scan stops at the first match or after
//   the last filled entry has been read. Clear, disabled lookups and the
//   reserved request code go straight to the result state without a scan.
//   One request is worked at a time; in_stall is high from acceptance until
//   the result has been moved into the output register, and the next request
//   is taken once the unit is back in its idle state.
//   The output register holds a finished result while out_stall is high; the
//   next request is still accepted meanwhile and waits in its result state.
//   Reset empties the table (fill count to zero), drops any result and loads
//   the register defaults: lookups off, empty virtual id range.
// ----------------------------------------------------------------------------
module keyed_override_table_unit #(
	parameter int TABLE_DEPTH = kot_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  kot_pkg::req_t in_req,
	output logic          out_valid,
	input  logic          out_stall,
	output kot_pkg::res_t out_res,
	input  logic          cfg_wr_en,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);

	import kot_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W = $bits(key_t);
	localparam int PAY_W = $bits(payload_t);

	// configuration
	logic       lookups_enabled_q;
	logic [7:0] virtual_id_low_q;
	logic [7:0] virtual_id_high_q;

	// control
	state_t           state_q, state_d;
	req_t             req_q;
	res_t             res_q, res_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             out_valid_q;
	res_t             out_q;

	// RAM ports
	logic             issue;
	logic             key_we, pay_we, count_inc;
	logic [IDX_W-1:0] wr_addr;
	key_t             key_wdata, key_rd;
	payload_t         pay_wdata, pay_rd;
	logic [KEY_W-1:0] key_rd_raw;
	logic [PAY_W-1:0] pay_rd_raw;

	// compare
	logic in_accept;
	logic needs_scan;
	logic exact_match, look_match, scan_hit, scan_end;
	logic is_virtual;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	assign needs_scan = (in_req.req_type == REQ_SET) ||
		((in_req.req_type == REQ_LOOKUP) && lookups_enabled_q);

	// issue one read per cycle while scanning, until every filled entry has been read
	assign issue = (state_q == S_SCAN) && (issue_q < count_q);

	assign key_wdata = '{area: req_q.area, indoors: req_q.indoors,
		sprite: req_q.sprite, half: req_q.half};
	assign pay_wdata = '{item: req_q.item, message_id: req_q.message_id,
		report_id: req_q.report_id};

	kot_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_key_ram (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (wr_addr),
		.wr_data (key_wdata),
		.rd_en   (issue),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (key_rd_raw)
	);

	kot_ram #(.WIDTH(PAY_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_pay_ram (
		.clk     (clk),
		.wr_en   (pay_we),
		.wr_addr (wr_addr),
		.wr_data (pay_wdata),
		.rd_en   (issue),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (pay_rd_raw)
	);

	assign key_rd = key_t'(key_rd_raw);
	assign pay_rd = payload_t'(pay_rd_raw);

	// Set needs the whole key equal, half included. Lookup ignores the half
	// outdoors; indoors the stored half is "either" or equals the half bit.
	always_comb begin
		exact_match = rd_valid_s1 && (key_rd == key_wdata);
		look_match  = rd_valid_s1 &&
			(key_rd.sprite == req_q.sprite) &&
			(key_rd.indoors == req_q.indoors) &&
			(key_rd.area == req_q.area) &&
			(!key_rd.indoors || (key_rd.half == HALF_ANY) ||
			 (key_rd.half == {1'b0, req_q.half[0]}));
		scan_hit = (req_q.req_type == REQ_SET) ? exact_match : look_match;
		// nothing in flight and nothing left to read: no entry matched
		scan_end = !rd_valid_s1 && !issue;
		is_virtual = (pay_rd.item >= virtual_id_low_q) &&
			(pay_rd.item <= virtual_id_high_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = needs_scan ? S_SCAN : S_RESULT;
				end
			end
			S_SCAN: begin
				if (scan_hit || scan_end) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// scan outcome: result, table write-back and fill count
	always_comb begin
		res_d     = res_q;
		key_we    = 1'b0;
		pay_we    = 1'b0;
		count_inc = 1'b0;
		wr_addr   = idx_s1;
		unique case (state_q)
			S_SCAN: begin
				if (req_q.req_type == REQ_SET) begin
					if (scan_hit) begin
						// overwrite payload of the matching entry
						pay_we = 1'b1;
						res_d  = empty_res(ST_UPDATED);
					end else if (scan_end) begin
						if (count_q >= CNT_W'(TABLE_DEPTH)) begin
							res_d = empty_res(ST_FULL);
						end else begin
							// append at the fill count
							wr_addr   = count_q[IDX_W-1:0];
							key_we    = 1'b1;
							pay_we    = 1'b1;
							count_inc = 1'b1;
							res_d     = empty_res(ST_ADDED);
						end
					end
				end else begin
					if (scan_hit) begin
						// first match decides; an oversized real item misses
						if ((pay_rd.item >= ITEM_LIMIT) && !is_virtual) begin
							res_d = empty_res(ST_MISS);
						end else begin
							res_d.status           = ST_HIT;
							res_d.found_item       = pay_rd.item;
							res_d.found_message_id = pay_rd.message_id;
							res_d.found_report_id  = pay_rd.report_id;
						end
					end else if (scan_end) begin
						res_d = empty_res(ST_MISS);
					end
				end
			end
			S_IDLE, S_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			count_q           <= '0;
			issue_q           <= '0;
			rd_valid_s1       <= 1'b0;
			out_valid_q       <= 1'b0;
			lookups_enabled_q <= 1'b0;
			virtual_id_low_q  <= 8'd255;
			virtual_id_high_q <= 8'd0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (issue) begin
				issue_q <= issue_q + 1'b1;
			end
			if (in_accept) begin
				issue_q <= '0;
				if (in_req.req_type == REQ_CLEAR) begin
					count_q <= '0;
				end
			end
			if (count_inc) begin
				count_q <= count_q + 1'b1;
			end
			// output register: load from the result state, else drop when taken
			if ((state_q == S_RESULT) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_LOOKUPS_ENABLED: lookups_enabled_q <= cfg_data[0];
					CFG_VIRTUAL_ID_LOW:  virtual_id_low_q  <= cfg_data;
					CFG_VIRTUAL_ID_HIGH: virtual_id_high_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[IDX_W-1:0];
		if (in_accept) begin
			req_q <= in_req;
			res_q <= (in_req.req_type == REQ_CLEAR) ? empty_res(ST_CLEARED) :
				empty_res(ST_MISS);
		end else if (state_q == S_SCAN) begin
			res_q <= res_d;
		end
		if ((state_q == S_RESULT) && (!out_valid_q || !out_stall)) begin
			out_q <= res_q;
		end
	end

endmodule

[rtl/kot_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kot_checker: port-level checks for the keyed override table
// Watches the request and result channels of the top level; bound below.
// ----------------------------------------------------------------------------
module kot_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input kot_pkg::req_t in_req,
	input logic          out_valid,
	input logic          out_stall,
	input kot_pkg::res_t out_res
);

	import kot_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_res))
		else $error("stalled result changed or dropped");

	// one request at a time: accepting one closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request accepted while busy");

	// only defined status codes leave the unit
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.status <= ST_MISS))
		else $error("undefined status code");

	// anything but a hit carries empty payload fields
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_res.status != ST_HIT) |->
			(out_res.found_item == 8'd0) &&
			(out_res.found_message_id == -16'sd1) &&
			(out_res.found_report_id == -16'sd1))
		else $error("non-hit result carries payload");

endmodule

bind keyed_override_table_unit kot_checker u_kot_checker (.*);
